/* hw/rtl/task_priority_queue_assert.svh */
// ----------------------------------------------------------------------------
// Task priority queue assertion macros
// Shared concurrent assertion forms for the task priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef TASK_PRIORITY_QUEUE_ASSERT_SVH
`define TASK_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define TPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("task priority queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("task priority queue check failed");

`else

`define TPQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define TPQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/tpq_pkg.sv */
// ----------------------------------------------------------------------------
// Task priority queue package
// Sizes, codes and shared types of the task priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

   localparam int TPQ_DEPTH     = 16;
   localparam int ID_W          = 8;
   localparam int PRI_W         = 4;
   localparam int BURST_W       = 16;
   localparam int TIME_W        = 32;
   localparam int SUM_W         = 40;
   localparam int COUNT_W       = 16;

   typedef enum logic {
      KIND_ADD = 1'b0,
      KIND_RUN = 1'b1
   } kind_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRI_W-1:0]   pri;
      logic [BURST_W-1:0] burst;
   } task_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic second_valid;
      logic near_full;
   } q_status_type;

   typedef struct packed {
      logic     run_hit;
      task_type head;
      logic     rejected;
      logic     empty_after;
      logic     full_after;
   } acct_item_type;

   typedef struct packed {
      logic               task_valid;
      task_type           run_task;
      logic [TIME_W-1:0]  start_time;
      logic [TIME_W-1:0]  finish_time;
      logic [SUM_W-1:0]   completion_sum;
      logic [SUM_W-1:0]   wait_sum;
      logic [COUNT_W-1:0] tasks_run;
      logic               add_rejected;
      logic               queue_empty;
      logic               queue_full;
   } result_type;

endpackage

/* hw/rtl/tpq_if.sv */
// ----------------------------------------------------------------------------
// Task priority queue channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tpq_req_if import tpq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [ID_W-1:0]    task_id;
   logic [PRI_W-1:0]   task_priority;
   logic [BURST_W-1:0] task_burst;

   modport source (output valid, kind, task_id, task_priority, task_burst, input ready);
   modport sink   (input valid, kind, task_id, task_priority, task_burst, output ready);
endinterface

interface tpq_rsp_if import tpq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               task_valid;
   logic [ID_W-1:0]    out_id;
   logic [PRI_W-1:0]   out_priority;
   logic [BURST_W-1:0] out_burst;
   logic [TIME_W-1:0]  start_time;
   logic [TIME_W-1:0]  finish_time;
   logic [SUM_W-1:0]   completion_sum;
   logic [SUM_W-1:0]   wait_sum;
   logic [COUNT_W-1:0] tasks_run;
   logic               add_rejected;
   logic               queue_empty;
   logic               queue_full;

   modport source (output valid, task_valid, out_id, out_priority, out_burst, start_time,
                   finish_time, completion_sum, wait_sum, tasks_run, add_rejected,
                   queue_empty, queue_full, input ready);
   modport sink   (input valid, task_valid, out_id, out_priority, out_burst, start_time,
                   finish_time, completion_sum, wait_sum, tasks_run, add_rejected,
                   queue_empty, queue_full, output ready);
endinterface

/* hw/rtl/tpq_cell.sv */
// ----------------------------------------------------------------------------
// Task priority queue cell
// One slot of the sorted queue; holds, takes a new task, or shifts.
// ----------------------------------------------------------------------------
module tpq_cell import tpq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     add_en,
   input  logic     run_en,
   input  task_type new_task,
   input  task_type left_task,
   input  logic     left_valid,
   input  logic     left_keep,
   input  task_type right_task,
   input  logic     right_valid,
   output task_type cell_task,
   output logic     cell_valid,
   output logic     keep
);

   task_type task_ff, task_in;
   logic     valid_ff, valid_in;

   // A cell keeps its task when it already ranks at or above the new one.
   assign keep       = valid_ff && (task_ff.pri >= new_task.pri);
   assign cell_task  = task_ff;
   assign cell_valid = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      task_in  = task_ff;
      if (add_en) begin
         if (!keep) begin
            valid_in = left_valid;
            task_in  = left_keep ? new_task : left_task;
         end
      end else if (run_en) begin
         valid_in = right_valid;
         task_in  = right_task;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff <= task_in;
   end

endmodule

/* hw/rtl/tpq_chain.sv */
// ----------------------------------------------------------------------------
// Task priority queue cell chain
// A row of cells kept sorted by priority, head at the first cell.
// ----------------------------------------------------------------------------
module tpq_chain import tpq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         add_en,
   input  logic         run_en,
   input  task_type     new_task,
   output task_type     head_task,
   output q_status_type status
);

   task_type cell_task [TPQ_DEPTH];
   logic     cell_valid [TPQ_DEPTH];
   logic     cell_keep [TPQ_DEPTH];

   for (genvar i = 0; i < TPQ_DEPTH; i++) begin : g_cell
      task_type left_task, right_task;
      logic     left_valid, left_keep, right_valid;

      if (i == 0) begin : g_first
         assign left_task  = new_task;
         assign left_valid = 1'b1;
         assign left_keep  = 1'b1;
      end else begin : g_inner_left
         assign left_task  = cell_task[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_keep  = cell_keep[i-1];
      end

      if (i == TPQ_DEPTH - 1) begin : g_last
         assign right_task  = cell_task[i];
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_task  = cell_task[i+1];
         assign right_valid = cell_valid[i+1];
      end

      tpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .add_en      (add_en),
         .run_en      (run_en),
         .new_task    (new_task),
         .left_task   (left_task),
         .left_valid  (left_valid),
         .left_keep   (left_keep),
         .right_task  (right_task),
         .right_valid (right_valid),
         .cell_task   (cell_task[i]),
         .cell_valid  (cell_valid[i]),
         .keep        (cell_keep[i])
      );
   end

   assign head_task           = cell_task[0];
   assign status.empty        = !cell_valid[0];
   assign status.full         = cell_valid[TPQ_DEPTH-1];
   assign status.second_valid = cell_valid[1];
   assign status.near_full    = cell_valid[TPQ_DEPTH-2];

endmodule

/* hw/rtl/tpq_acct.sv */
// ----------------------------------------------------------------------------
// Task priority queue accountant
// Tracks elapsed time and saturating totals, and holds the result register.
// ----------------------------------------------------------------------------
module tpq_acct import tpq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_take,
   input  acct_item_type in_item,
   output logic          in_ready,
   input  logic          out_ready,
   output logic          out_valid,
   output result_type    out_result
);

   typedef struct packed {
      logic              run_hit;
      task_type          run_task;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] finish_time;
      logic              rejected;
      logic              empty_after;
      logic              full_after;
   } stage_type;

   logic               a_valid_ff, a_valid_in;
   stage_type          a_ff, a_in;
   logic               b_valid_ff, b_valid_in;
   result_type         b_ff, b_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [SUM_W-1:0]   comp_total_ff, comp_total_in;
   logic [SUM_W-1:0]   wait_total_ff, wait_total_in;
   logic [COUNT_W-1:0] run_count_ff, run_count_in;
   logic [TIME_W:0]    finish_wide;
   logic [TIME_W-1:0]  finish_sat;
   logic [SUM_W:0]     comp_wide, wait_wide;
   logic               b_adv;

   assign b_adv     = a_valid_ff && (!b_valid_ff || out_ready);
   assign in_ready  = !a_valid_ff || b_adv;
   assign out_valid = b_valid_ff;
   assign out_result = b_ff;

   assign finish_wide = {1'b0, elapsed_ff} + {{(TIME_W + 1 - BURST_W){1'b0}}, in_item.head.burst};
   assign finish_sat  = finish_wide[TIME_W] ? {TIME_W{1'b1}} : finish_wide[TIME_W-1:0];

   assign comp_wide = {1'b0, comp_total_ff} + {{(SUM_W + 1 - TIME_W){1'b0}}, a_ff.finish_time};
   assign wait_wide = {1'b0, wait_total_ff} + {{(SUM_W + 1 - TIME_W){1'b0}}, a_ff.start_time};

   always_comb begin
      a_valid_in = a_valid_ff;
      a_in       = a_ff;
      elapsed_in = elapsed_ff;
      if (b_adv) begin
         a_valid_in = 1'b0;
      end
      if (in_take) begin
         a_valid_in       = 1'b1;
         a_in.run_hit     = in_item.run_hit;
         a_in.rejected    = in_item.rejected;
         a_in.empty_after = in_item.empty_after;
         a_in.full_after  = in_item.full_after;
         if (in_item.run_hit) begin
            a_in.run_task    = in_item.head;
            a_in.start_time  = elapsed_ff;
            a_in.finish_time = finish_sat;
            elapsed_in       = finish_sat;
         end else begin
            a_in.run_task    = '0;
            a_in.start_time  = '0;
            a_in.finish_time = '0;
         end
      end
   end

   always_comb begin
      b_valid_in    = b_valid_ff;
      b_in          = b_ff;
      comp_total_in = comp_total_ff;
      wait_total_in = wait_total_ff;
      run_count_in  = run_count_ff;
      if (b_valid_ff && out_ready) begin
         b_valid_in = 1'b0;
      end
      if (b_adv) begin
         if (a_ff.run_hit) begin
            comp_total_in = comp_wide[SUM_W] ? {SUM_W{1'b1}} : comp_wide[SUM_W-1:0];
            wait_total_in = wait_wide[SUM_W] ? {SUM_W{1'b1}} : wait_wide[SUM_W-1:0];
            run_count_in  = (&run_count_ff) ? run_count_ff : run_count_ff + COUNT_W'(1);
         end
         b_valid_in          = 1'b1;
         b_in.task_valid     = a_ff.run_hit;
         b_in.run_task       = a_ff.run_task;
         b_in.start_time     = a_ff.start_time;
         b_in.finish_time    = a_ff.finish_time;
         b_in.completion_sum = comp_total_in;
         b_in.wait_sum       = wait_total_in;
         b_in.tasks_run      = run_count_in;
         b_in.add_rejected   = a_ff.rejected;
         b_in.queue_empty    = a_ff.empty_after;
         b_in.queue_full     = a_ff.full_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         elapsed_ff    <= '0;
         comp_total_ff <= '0;
         wait_total_ff <= '0;
         run_count_ff  <= '0;
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         elapsed_ff    <= elapsed_in;
         comp_total_ff <= comp_total_in;
         wait_total_ff <= wait_total_in;
         run_count_ff  <= run_count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

/* hw/rtl/task_priority_queue.sv */
// ----------------------------------------------------------------------------
// Task priority queue
// Stable sorted queue of tasks in a chain of cells, with a run-time
// accountant that reports start, finish and saturating running totals.
//
//   Channel   Direction  Transfer carries
//   req_chan  in         kind, task_id, task_priority, task_burst
//   rsp_chan  out        one result per request, in request order
//
// A request is taken every cycle while the result side keeps up; the queue
// cells update in the cycle of the transfer and the result then passes through
// the timing stage and the result register.
// Reset empties the queue and clears all totals.
// A stalled result holds the two pipeline stages, and then the request side.
// ----------------------------------------------------------------------------
`include "task_priority_queue_assert.svh"

module task_priority_queue import tpq_pkg::*; (
   input logic        clock,
   input logic        reset,
   tpq_req_if.sink    req_chan,
   tpq_rsp_if.source  rsp_chan
);

   logic          req_accept;
   logic          is_run;
   logic          add_en;
   logic          run_en;
   task_type      new_task;
   task_type      head_task;
   q_status_type  q_status;
   acct_item_type item;
   result_type    result;
   logic          acct_ready;

   assign req_chan.ready = acct_ready;
   assign req_accept     = req_chan.valid && acct_ready;
   assign is_run         = (kind_type'(req_chan.kind) == KIND_RUN);
   assign add_en         = req_accept && !is_run && !q_status.full;
   assign run_en         = req_accept && is_run && !q_status.empty;

   assign new_task.id    = req_chan.task_id;
   assign new_task.pri   = req_chan.task_priority;
   assign new_task.burst = req_chan.task_burst;

   tpq_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .add_en    (add_en),
      .run_en    (run_en),
      .new_task  (new_task),
      .head_task (head_task),
      .status    (q_status)
   );

   assign item.run_hit     = is_run && !q_status.empty;
   assign item.head        = head_task;
   assign item.rejected    = !is_run && q_status.full;
   assign item.empty_after = is_run ? (q_status.empty || !q_status.second_valid) : 1'b0;
   assign item.full_after  = is_run ? 1'b0 : (q_status.full || q_status.near_full);

   tpq_acct u_acct (
      .clock      (clock),
      .reset      (reset),
      .in_take    (req_accept),
      .in_item    (item),
      .in_ready   (acct_ready),
      .out_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_result (result)
   );

   assign rsp_chan.task_valid     = result.task_valid;
   assign rsp_chan.out_id         = result.run_task.id;
   assign rsp_chan.out_priority   = result.run_task.pri;
   assign rsp_chan.out_burst      = result.run_task.burst;
   assign rsp_chan.start_time     = result.start_time;
   assign rsp_chan.finish_time    = result.finish_time;
   assign rsp_chan.completion_sum = result.completion_sum;
   assign rsp_chan.wait_sum       = result.wait_sum;
   assign rsp_chan.tasks_run      = result.tasks_run;
   assign rsp_chan.add_rejected   = result.add_rejected;
   assign rsp_chan.queue_empty    = result.queue_empty;
   assign rsp_chan.queue_full     = result.queue_full;

   `TPQ_ASSERT_SAME(a_full_not_empty, clock, reset, q_status.full, !q_status.empty)
   `TPQ_ASSERT_NEXT(a_reject_keeps_full, clock, reset, req_accept && item.rejected, q_status.full)
   `TPQ_ASSERT_NEXT(a_run_frees_slot, clock, reset, run_en, !q_status.full)

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Task priority queue testbench
// Drives add and run requests into the scheduler queue with random gaps on
// both channels. A behavioural scheduler predicts every result, and each
// result transfer is checked field by field. A short run of maximum bursts
// then pushes the elapsed time and the sums up quickly.
// ----------------------------------------------------------------------------
module tb_top import tpq_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      kind_type           kind;
      logic [ID_W-1:0]    id;
      logic [PRI_W-1:0]   pri;
      logic [BURST_W-1:0] burst;
   } sched_req_type;

   localparam int IDLE_PCT    = 22;
   localparam int QUIET_FIRST = 600;
   localparam int QUIET_LAST  = 1100;
   localparam int SAT_PAIRS   = 25;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpq_req_if req_chan ();
   tpq_rsp_if rsp_chan ();

   task_priority_queue dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   sched_req_type pending_reqs[$];
   result_type    expected_results[$];
   sched_req_type on_wire;
   int            error_count = 0;
   int            cycle_count = 0;

   // Shadow of the scheduler state.
   task_type           shadow_slots[TPQ_DEPTH];
   int                 shadow_count = 0;
   logic [TIME_W-1:0]  shadow_elapsed = '0;
   logic [SUM_W-1:0]   shadow_completion = '0;
   logic [SUM_W-1:0]   shadow_wait = '0;
   logic [COUNT_W-1:0] shadow_runs = '0;

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
               cycle_count, what, got, want);
      error_count++;
   endtask

   function automatic result_type schedule_step(input sched_req_type r);
      result_type      res;
      int              pos;
      longint unsigned fin;
      res = '0;
      if (r.kind == KIND_ADD) begin
         if (shadow_count >= TPQ_DEPTH) begin
            res.add_rejected = 1'b1;
         end else begin
            pos = 0;
            while (pos < shadow_count && shadow_slots[pos].pri >= r.pri) pos++;
            for (int i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
            shadow_slots[pos] = '{id: r.id, pri: r.pri, burst: r.burst};
            shadow_count++;
         end
      end else if (shadow_count > 0) begin
         res.task_valid = 1'b1;
         res.run_task   = shadow_slots[0];
         for (int i = 0; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i+1];
         shadow_count--;
         res.start_time = shadow_elapsed;
         fin = longint'(shadow_elapsed) + longint'(res.run_task.burst);
         if (fin > 64'hFFFF_FFFF) fin = 64'hFFFF_FFFF;
         res.finish_time = fin[TIME_W-1:0];
         shadow_elapsed  = fin[TIME_W-1:0];
         if (longint'(shadow_completion) + fin > 64'hFF_FFFF_FFFF) begin
            shadow_completion = '1;
         end else begin
            shadow_completion = shadow_completion + fin[SUM_W-1:0];
         end
         if (longint'(shadow_wait) + longint'(res.start_time) > 64'hFF_FFFF_FFFF) begin
            shadow_wait = '1;
         end else begin
            shadow_wait = shadow_wait + res.start_time;
         end
         if (shadow_runs != '1) shadow_runs = shadow_runs + 1'b1;
      end
      res.completion_sum = shadow_completion;
      res.wait_sum       = shadow_wait;
      res.tasks_run      = shadow_runs;
      res.queue_empty    = (shadow_count == 0);
      res.queue_full     = (shadow_count >= TPQ_DEPTH);
      return res;
   endfunction

   function automatic sched_req_type make_req(input kind_type k, input int id, input int pri,
                                              input int burst);
      sched_req_type r;
      r.kind  = k;
      r.id    = id[ID_W-1:0];
      r.pri   = pri[PRI_W-1:0];
      r.burst = burst[BURST_W-1:0];
      return r;
   endfunction

   function automatic sched_req_type random_req(input int add_pct);
      sched_req_type r;
      int            burst;
      case ($urandom_range(3))
         0: burst = $urandom_range(1) ? 65535 : 0;
         1: burst = $urandom_range(100);
         default: burst = $urandom_range(65535);
      endcase
      r = make_req(($urandom_range(99) < add_pct) ? KIND_ADD : KIND_RUN,
                   $urandom_range(255),
                   $urandom_range(1) ? $urandom_range(15) : $urandom_range(2), burst);
      return r;
   endfunction

   function automatic bit quiet_window();
      return cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(schedule_step(on_wire));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_reqs.size() > 0 &&
                (quiet_window() || $urandom_range(99) >= IDLE_PCT)) begin
               on_wire = pending_reqs.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.kind          <= on_wire.kind;
               req_chan.task_id       <= on_wire.id;
               req_chan.task_priority <= on_wire.pri;
               req_chan.task_burst    <= on_wire.burst;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result transfer", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.task_valid !== want.task_valid)
                  report_mismatch("task_valid", rsp_chan.task_valid, want.task_valid);
               if (rsp_chan.out_id !== want.run_task.id)
                  report_mismatch("out_id", rsp_chan.out_id, want.run_task.id);
               if (rsp_chan.out_priority !== want.run_task.pri)
                  report_mismatch("out_priority", rsp_chan.out_priority, want.run_task.pri);
               if (rsp_chan.out_burst !== want.run_task.burst)
                  report_mismatch("out_burst", rsp_chan.out_burst, want.run_task.burst);
               if (rsp_chan.start_time !== want.start_time)
                  report_mismatch("start_time", rsp_chan.start_time, want.start_time);
               if (rsp_chan.finish_time !== want.finish_time)
                  report_mismatch("finish_time", rsp_chan.finish_time, want.finish_time);
               if (rsp_chan.completion_sum !== want.completion_sum)
                  report_mismatch("completion_sum", rsp_chan.completion_sum,
                                  want.completion_sum);
               if (rsp_chan.wait_sum !== want.wait_sum)
                  report_mismatch("wait_sum", rsp_chan.wait_sum, want.wait_sum);
               if (rsp_chan.tasks_run !== want.tasks_run)
                  report_mismatch("tasks_run", rsp_chan.tasks_run, want.tasks_run);
               if (rsp_chan.add_rejected !== want.add_rejected)
                  report_mismatch("add_rejected", rsp_chan.add_rejected, want.add_rejected);
               if (rsp_chan.queue_empty !== want.queue_empty)
                  report_mismatch("queue_empty", rsp_chan.queue_empty, want.queue_empty);
               if (rsp_chan.queue_full !== want.queue_full)
                  report_mismatch("queue_full", rsp_chan.queue_full, want.queue_full);
            end
         end
         rsp_chan.ready <= quiet_window() || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      #30ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int add_pct;
      int drain;
      req_chan.valid         = 1'b0;
      req_chan.kind          = KIND_ADD;
      req_chan.task_id       = '0;
      req_chan.task_priority = '0;
      req_chan.task_burst    = '0;
      rsp_chan.ready         = 1'b0;

      // A run on the empty queue carries junk fields that must be ignored.
      pending_reqs.push_back(make_req(KIND_RUN, 255, 15, 65535));
      pending_reqs.push_back(make_req(KIND_ADD, 0, 0, 0));
      pending_reqs.push_back(make_req(KIND_ADD, 255, 15, 65535));
      // Equal priorities must leave in arrival order.
      pending_reqs.push_back(make_req(KIND_ADD, 16, 7, 100));
      pending_reqs.push_back(make_req(KIND_ADD, 17, 7, 200));
      pending_reqs.push_back(make_req(KIND_ADD, 18, 7, 300));
      pending_reqs.push_back(make_req(KIND_ADD, 19, 15, 1));
      pending_reqs.push_back(make_req(KIND_ADD, 20, 0, 2));
      for (int i = 0; i < 9; i++) begin
         pending_reqs.push_back(make_req(KIND_ADD, 32 + i, i % 16, 1000 * i));
      end
      // The queue is full now, so this add is dropped.
      pending_reqs.push_back(make_req(KIND_ADD, 170, 15, 5));
      for (int i = 0; i < 6; i++) begin
         pending_reqs.push_back(make_req(KIND_RUN, 85, 10, 43690));
      end

      // Segments with different add rates make the occupancy sweep from
      // empty to full and back again.
      for (int seg = 0; seg < 19; seg++) begin
         case ($urandom_range(3))
            0: add_pct = 15;
            1: add_pct = 50;
            2: add_pct = 70;
            default: add_pct = 95;
         endcase
         for (int i = 0; i < 50; i++) pending_reqs.push_back(random_req(add_pct));
      end

      // Paired adds and runs of maximum bursts push the elapsed time up quickly.
      for (int i = 0; i < SAT_PAIRS; i++) begin
         pending_reqs.push_back(make_req(KIND_ADD, $urandom_range(255), $urandom_range(15),
                                         65535));
         pending_reqs.push_back(make_req(KIND_RUN, $urandom_range(255), $urandom_range(15),
                                         $urandom_range(65535)));
      end
      for (int i = 0; i < 20; i++) pending_reqs.push_back(random_req(30));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_chan.valid) @(posedge clock);
      drain = 0;
      while (expected_results.size() > 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (expected_results.size() > 0) begin
         report_mismatch("results never delivered", 0, expected_results.size());
      end

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
